### rtl/core/ars_pkg.sv
// Shared widths and constants for the adaptive rANS symbol decoder.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package ars_pkg;

    localparam int STATE_W     = 32;
    localparam int SYM_W       = 9;
    localparam int CUM_W       = 16;
    localparam int FREQ_W      = 16;
    localparam int LOW_W       = 15;
    localparam int BOOST_W     = 12;
    localparam int TOTAL       = 32'h8000;
    localparam int STEP_INC    = 31;
    localparam int BOOST_RESET = 725;

endpackage

`default_nettype wire

### rtl/core/ars_tables.sv
// Cumulative-frequency and frequency-count memories of the decoder model.
// Each has one write port and one registered read port; uses ars_pkg.
`default_nettype none

module ars_tables #(
    parameter int NUM_SYMBOLS = 300,
    localparam int CW = $clog2(NUM_SYMBOLS + 1),
    localparam int FW = $clog2(NUM_SYMBOLS)
) (
    input  wire logic                      clk,
    input  wire logic                      cum_we,
    input  wire logic [CW-1:0]             cum_wr_addr,
    input  wire logic [ars_pkg::CUM_W-1:0] cum_wr_data,
    input  wire logic [CW-1:0]             cum_rd_addr,
    output logic      [ars_pkg::CUM_W-1:0] cum_rd_data,
    input  wire logic                      freq_we,
    input  wire logic [FW-1:0]             freq_wr_addr,
    input  wire logic [ars_pkg::FREQ_W-1:0] freq_wr_data,
    input  wire logic [FW-1:0]             freq_rd_addr,
    output logic      [ars_pkg::FREQ_W-1:0] freq_rd_data
);

    logic [ars_pkg::CUM_W-1:0]  cum_mem  [NUM_SYMBOLS + 1];
    logic [ars_pkg::FREQ_W-1:0] freq_mem [NUM_SYMBOLS];

    always_ff @(posedge clk)
    begin
        if (cum_we)
        begin
            cum_mem[cum_wr_addr] <= cum_wr_data;
        end
        cum_rd_data <= cum_mem[cum_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (freq_we)
        begin
            freq_mem[freq_wr_addr] <= freq_wr_data;
        end
        freq_rd_data <= freq_mem[freq_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/ars_seq.sv
// Sequencer and shared datapath: table initialisation, bitwise interval search,
// state update, count update and periodic model adaptation. Uses ars_pkg.
`default_nettype none

module ars_seq #(
    parameter int NUM_SYMBOLS     = 300,
    parameter int UNIFORM_SYMBOLS = 264,
    parameter int ADAPT_PERIOD    = 1024,
    localparam int CW = $clog2(NUM_SYMBOLS + 1),
    localparam int FW = $clog2(NUM_SYMBOLS)
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ars_pkg::STATE_W-1:0] state_in,
    input  wire logic [ars_pkg::BOOST_W-1:0] adapt_boost,
    output logic                             busy,
    output logic                             done,
    output logic      [ars_pkg::SYM_W-1:0]   symbol,
    output logic      [ars_pkg::STATE_W-1:0] state_out,
    output logic                             cum_we,
    output logic      [CW-1:0]               cum_wr_addr,
    output logic      [ars_pkg::CUM_W-1:0]   cum_wr_data,
    output logic      [CW-1:0]               cum_rd_addr,
    input  wire logic [ars_pkg::CUM_W-1:0]   cum_rd_data,
    output logic                             freq_we,
    output logic      [FW-1:0]               freq_wr_addr,
    output logic      [ars_pkg::FREQ_W-1:0]  freq_wr_data,
    output logic      [FW-1:0]               freq_rd_addr,
    input  wire logic [ars_pkg::FREQ_W-1:0]  freq_rd_data
);

    localparam int U_EFF  = (UNIFORM_SYMBOLS > NUM_SYMBOLS) ? NUM_SYMBOLS : UNIFORM_SYMBOLS;
    localparam int KNUM   = ars_pkg::TOTAL - NUM_SYMBOLS + U_EFF;
    localparam int Q_STEP = KNUM / U_EFF;
    localparam int R_STEP = KNUM % U_EFF;
    localparam int R_W    = $clog2(2 * U_EFF);
    localparam int SUM_W  = ars_pkg::FREQ_W + FW;
    localparam int CNT_W  = 11;

    localparam logic [ars_pkg::CUM_W-1:0] TAIL_BASE =
        ars_pkg::CUM_W'(ars_pkg::TOTAL - NUM_SYMBOLS);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_HI_RD,
        ST_MUL,
        ST_FIN,
        ST_AD_RD,
        ST_AD_WR
    } state_t;

    state_t                      state_reg, state_next;
    logic [ars_pkg::STATE_W-1:0] st_reg, st_next;
    logic [FW-1:0]               sym_reg, sym_next;
    logic [FW-1:0]               mask_reg, mask_next;
    logic [ars_pkg::CUM_W-1:0]   lo_reg, lo_next;
    logic [ars_pkg::STATE_W-1:0] prod_reg, prod_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [SUM_W-1:0]            sum_reg, sum_next;
    logic [ars_pkg::CUM_W-1:0]   q_reg, q_next;
    logic [R_W-1:0]              r_reg, r_next;
    logic                        done_reg, done_next;
    logic [ars_pkg::SYM_W-1:0]   symbol_reg, symbol_next;
    logic [ars_pkg::STATE_W-1:0] state_out_reg, state_out_next;

    logic [FW-1:0]               cand;
    logic [ars_pkg::LOW_W-1:0]   low;
    logic [ars_pkg::CUM_W-1:0]   diff;
    logic [ars_pkg::STATE_W:0]   prod_full;
    logic [ars_pkg::FREQ_W-1:0]  freq_adj;
    logic [SUM_W-1:0]            sum_add;
    logic [SUM_W:0]              mid_full;
    logic [R_W-1:0]              r_add;

    assign cand      = sym_reg | mask_reg;
    assign low       = st_reg[ars_pkg::LOW_W-1:0];
    assign diff      = cum_rd_data - lo_reg;
    assign prod_full = st_reg[ars_pkg::STATE_W-1:ars_pkg::LOW_W] * diff;
    assign freq_adj  = (idx_reg == CW'(sym_reg))
                     ? freq_rd_data + ars_pkg::FREQ_W'(adapt_boost)
                     : freq_rd_data;
    assign sum_add   = sum_reg + SUM_W'(freq_adj);
    assign mid_full  = (SUM_W + 1)'(cum_rd_data) + (SUM_W + 1)'(sum_add);
    assign r_add     = r_reg + R_W'(R_STEP);

    always_comb
    begin
        state_next     = state_reg;
        st_next        = st_reg;
        sym_next       = sym_reg;
        mask_next      = mask_reg;
        lo_next        = lo_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        done_next      = 1'b0;
        symbol_next    = symbol_reg;
        state_out_next = state_out_reg;

        cum_we       = 1'b0;
        cum_wr_addr  = idx_reg;
        cum_wr_data  = q_reg;
        cum_rd_addr  = '0;
        freq_we      = 1'b0;
        freq_wr_addr = idx_reg[FW-1:0];
        freq_wr_data = ars_pkg::FREQ_W'(1);
        freq_rd_addr = '0;

        case (state_reg)
            ST_INIT:
            begin
                cum_we      = 1'b1;
                cum_wr_data = (idx_reg < CW'(U_EFF)) ? q_reg : TAIL_BASE + ars_pkg::CUM_W'(idx_reg);
                freq_we     = (idx_reg < CW'(NUM_SYMBOLS));
                if (r_add >= R_W'(U_EFF))
                begin
                    r_next = r_add - R_W'(U_EFF);
                    q_next = q_reg + ars_pkg::CUM_W'(Q_STEP) + ars_pkg::CUM_W'(1);
                end
                else
                begin
                    r_next = r_add;
                    q_next = q_reg + ars_pkg::CUM_W'(Q_STEP);
                end
                if (idx_reg == CW'(NUM_SYMBOLS))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    st_next    = state_in;
                    sym_next   = '0;
                    lo_next    = '0;
                    mask_next  = FW'(1) << (FW - 1);
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD:
            begin
                cum_rd_addr = CW'(cand);
                if (cand <= FW'(NUM_SYMBOLS - 1))
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (mask_reg[0])
                begin
                    state_next = ST_HI_RD;
                end
                else
                begin
                    mask_next = mask_reg >> 1;
                end
            end
            ST_SRCH_CMP:
            begin
                if (cum_rd_data <= ars_pkg::CUM_W'(low))
                begin
                    sym_next = cand;
                    lo_next  = cum_rd_data;
                end
                if (mask_reg[0])
                begin
                    state_next = ST_HI_RD;
                end
                else
                begin
                    mask_next  = mask_reg >> 1;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_HI_RD:
            begin
                cum_rd_addr  = CW'(sym_reg) + CW'(1);
                freq_rd_addr = sym_reg;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next    = prod_full[ars_pkg::STATE_W-1:0];
                freq_we      = 1'b1;
                freq_wr_addr = sym_reg;
                freq_wr_data = freq_rd_data + ars_pkg::FREQ_W'(ars_pkg::STEP_INC);
                cnt_next     = cnt_reg - CNT_W'(1);
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                state_out_next = ars_pkg::STATE_W'(low) + prod_reg
                               - ars_pkg::STATE_W'(lo_reg);
                symbol_next    = ars_pkg::SYM_W'(sym_reg);
                done_next      = 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = CNT_W'(ADAPT_PERIOD);
                    idx_next   = '0;
                    sum_next   = '0;
                    state_next = ST_AD_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_AD_RD:
            begin
                freq_rd_addr = idx_reg[FW-1:0];
                cum_rd_addr  = idx_reg + CW'(1);
                state_next   = ST_AD_WR;
            end
            ST_AD_WR:
            begin
                sum_next    = sum_add;
                cum_we      = 1'b1;
                cum_wr_addr = idx_reg + CW'(1);
                cum_wr_data = mid_full[ars_pkg::CUM_W:1];
                freq_we     = 1'b1;
                if (idx_reg == CW'(NUM_SYMBOLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_AD_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            st_reg        <= '0;
            sym_reg       <= '0;
            mask_reg      <= '0;
            lo_reg        <= '0;
            prod_reg      <= '0;
            cnt_reg       <= CNT_W'(ADAPT_PERIOD);
            idx_reg       <= '0;
            sum_reg       <= '0;
            q_reg         <= '0;
            r_reg         <= '0;
            done_reg      <= 1'b0;
            symbol_reg    <= '0;
            state_out_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            st_reg        <= st_next;
            sym_reg       <= sym_next;
            mask_reg      <= mask_next;
            lo_reg        <= lo_next;
            prod_reg      <= prod_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            q_reg         <= q_next;
            r_reg         <= r_next;
            done_reg      <= done_next;
            symbol_reg    <= symbol_next;
            state_out_reg <= state_out_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign symbol    = symbol_reg;
    assign state_out = state_out_reg;

endmodule

`default_nettype wire

### rtl/core/adaptive_rans_symbol_decoder.sv
// Top level of the adaptive rANS symbol decoder: boost register, sequencer and tables.
// Depends on ars_pkg, ars_seq and ars_tables.
//
// A transfer is taken when start is high and busy is low; its result appears on symbol
// and state_out for exactly one cycle while done is high, and cannot be held off, so
// the receiver must take it then. The duration of an item is set by the bitwise
// interval search, which waits on the single registered read port of the cumulative
// table for every bit whose candidate symbol lies inside the alphabet. Every
// ADAPT_PERIOD-th item is followed by an adaptation pass, and after reset an
// initialisation pass loads the tables; busy stays high through both. The boost
// register should be written only while busy is low, since an adaptation pass
// reads it.
`default_nettype none

module adaptive_rans_symbol_decoder #(
    parameter int NUM_SYMBOLS     = 300,
    parameter int UNIFORM_SYMBOLS = 264,
    parameter int ADAPT_PERIOD    = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [ars_pkg::STATE_W-1:0] state_in,
    output logic                             done,
    output logic      [ars_pkg::SYM_W-1:0]   symbol,
    output logic      [ars_pkg::STATE_W-1:0] state_out,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ars_pkg::BOOST_W-1:0] cfg_wr_data
);

    localparam int CW = $clog2(NUM_SYMBOLS + 1);
    localparam int FW = $clog2(NUM_SYMBOLS);

    logic [ars_pkg::BOOST_W-1:0] adapt_boost_reg;

    logic                       cum_we;
    logic [CW-1:0]              cum_wr_addr;
    logic [ars_pkg::CUM_W-1:0]  cum_wr_data;
    logic [CW-1:0]              cum_rd_addr;
    logic [ars_pkg::CUM_W-1:0]  cum_rd_data;
    logic                       freq_we;
    logic [FW-1:0]              freq_wr_addr;
    logic [ars_pkg::FREQ_W-1:0] freq_wr_data;
    logic [FW-1:0]              freq_rd_addr;
    logic [ars_pkg::FREQ_W-1:0] freq_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adapt_boost_reg <= ars_pkg::BOOST_W'(ars_pkg::BOOST_RESET);
        end
        else if (cfg_wr_en)
        begin
            adapt_boost_reg <= cfg_wr_data;
        end
    end

    ars_seq #(
        .NUM_SYMBOLS     (NUM_SYMBOLS),
        .UNIFORM_SYMBOLS (UNIFORM_SYMBOLS),
        .ADAPT_PERIOD    (ADAPT_PERIOD)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .state_in     (state_in),
        .adapt_boost  (adapt_boost_reg),
        .busy         (busy),
        .done         (done),
        .symbol       (symbol),
        .state_out    (state_out),
        .cum_we       (cum_we),
        .cum_wr_addr  (cum_wr_addr),
        .cum_wr_data  (cum_wr_data),
        .cum_rd_addr  (cum_rd_addr),
        .cum_rd_data  (cum_rd_data),
        .freq_we      (freq_we),
        .freq_wr_addr (freq_wr_addr),
        .freq_wr_data (freq_wr_data),
        .freq_rd_addr (freq_rd_addr),
        .freq_rd_data (freq_rd_data)
    );

    ars_tables #(
        .NUM_SYMBOLS (NUM_SYMBOLS)
    ) u_tables (
        .clk          (clk),
        .cum_we       (cum_we),
        .cum_wr_addr  (cum_wr_addr),
        .cum_wr_data  (cum_wr_data),
        .cum_rd_addr  (cum_rd_addr),
        .cum_rd_data  (cum_rd_data),
        .freq_we      (freq_we),
        .freq_wr_addr (freq_wr_addr),
        .freq_wr_data (freq_wr_data),
        .freq_rd_addr (freq_rd_addr),
        .freq_rd_data (freq_rd_data)
    );

endmodule

`default_nettype wire

### rtl/core/ars_checker.sv
// Port-level checks on the adaptive rANS symbol decoder, bound to its top level.
// Depends on adaptive_rans_symbol_decoder and ars_pkg.
`default_nettype none

module ars_checker #(
    parameter int NUM_SYMBOLS = 300
) (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic [ars_pkg::SYM_W-1:0] symbol
);

    a_accept_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("Block not busy after an accepted transfer.");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("Result shown in the cycle after acceptance.");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Result strobe held for more than one cycle.");

    a_symbol_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, symbol} < (ars_pkg::SYM_W + 1)'(NUM_SYMBOLS)))
        else $error("Decoded symbol outside the alphabet.");

endmodule

bind adaptive_rans_symbol_decoder ars_checker #(
    .NUM_SYMBOLS (NUM_SYMBOLS)
) u_ars_checker (.*);

`default_nettype wire
